// ===== rtl/core/ssvu_pkg.sv =====
// ssvu_pkg: types and character constants shared by the field unescape block
// no dependencies

package ssvu_pkg;

    localparam logic [7:0] C_AT = 8'h40;
    localparam logic [7:0] C_US = 8'h5F;
    localparam logic [7:0] C_BS = 8'h5C;
    localparam logic [7:0] C_SP = 8'h20;
    localparam logic [7:0] C_NL = 8'h0A;

    localparam int unsigned MAX_RES = 3;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       has_char;
        logic       end_of_field;
    } t_out_item;

    // results of one request, slot 0 first
    typedef struct packed {
        t_out_item [MAX_RES-1:0] slot;
        logic [1:0]              cnt;
    } t_res_set;

    function automatic t_res_set f_put(t_res_set s, logic [7:0] ch);
        t_res_set r;
        r = s;
        case (s.cnt)
            2'd0: begin
                r.slot[0] = '{out_char: ch, has_char: 1'b1, end_of_field: 1'b0};
            end
            2'd1: begin
                r.slot[1] = '{out_char: ch, has_char: 1'b1, end_of_field: 1'b0};
            end
            default: begin
                r.slot[2] = '{out_char: ch, has_char: 1'b1, end_of_field: 1'b0};
            end
        endcase
        r.cnt = s.cnt + 2'd1;
        return r;
    endfunction

endpackage

// ===== rtl/core/ssvu_decode.sv =====
// ssvu_decode: field state registers and the single-pass decode of one request
// depends on ssvu_pkg

module ssvu_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  ssvu_pkg::t_in_item i_item,
    output ssvu_pkg::t_res_set o_set
);

    logic [7:0] r_held0, r_held1, n_held0, n_held1;
    logic [1:0] r_held_cnt, n_held_cnt;
    logic [7:0] r_prev, n_prev;
    logic       r_start, n_start;
    logic       r_esc, n_esc;

    ssvu_pkg::t_res_set rs;
    logic       done;
    logic       drop;
    logic [7:0] c;

    always_comb begin
        c          = i_item.char_in;
        n_held0    = r_held0;
        n_held1    = r_held1;
        n_held_cnt = r_held_cnt;
        n_prev     = r_prev;
        n_start    = r_start;
        n_esc      = r_esc;
        rs         = '0;
        done       = 1'b0;
        drop       = 1'b0;
        if (i_item.kind) begin
            if (r_esc) begin
                rs = ssvu_pkg::f_put(rs, ssvu_pkg::C_BS);
            end else if (r_held_cnt == 2'd1 && !r_start && r_prev != ssvu_pkg::C_SP) begin
                rs = ssvu_pkg::f_put(rs, r_held0);
            end else if (r_held_cnt == 2'd2) begin
                rs = ssvu_pkg::f_put(rs, r_held1);
            end
            // the end request always yields exactly one result
            rs.cnt                   = 2'd1;
            rs.slot[0].end_of_field  = 1'b1;
            n_held0    = '0;
            n_held1    = '0;
            n_held_cnt = '0;
            n_prev     = '0;
            n_start    = 1'b1;
            n_esc      = 1'b0;
        end else begin
            if (r_esc) begin
                n_esc   = 1'b0;
                n_start = 1'b0;
                if (c == ssvu_pkg::C_AT || c == ssvu_pkg::C_US) begin
                    rs     = ssvu_pkg::f_put(rs, c);
                    n_prev = c;
                    done   = 1'b1;
                end else begin
                    rs     = ssvu_pkg::f_put(rs, ssvu_pkg::C_BS);
                    n_prev = ssvu_pkg::C_BS;
                end
            end
            if (!done) begin
                if (n_held_cnt == 2'd1) begin
                    if (n_start && c == ssvu_pkg::C_NL) begin
                        // "@" newline at the field start waits for the end
                        n_held1    = c;
                        n_held_cnt = 2'd2;
                        done       = 1'b1;
                    end else begin
                        if (n_start) begin
                            drop = (c == ssvu_pkg::C_SP);
                        end else begin
                            drop = (n_prev == ssvu_pkg::C_SP) &&
                                   (c == ssvu_pkg::C_SP || c == ssvu_pkg::C_NL);
                        end
                        if (!drop) begin
                            rs = ssvu_pkg::f_put(rs, n_held0);
                        end
                        n_prev     = n_held0;
                        n_held_cnt = 2'd0;
                        n_start    = 1'b0;
                    end
                end else if (n_held_cnt == 2'd2) begin
                    rs         = ssvu_pkg::f_put(rs, n_held0);
                    rs         = ssvu_pkg::f_put(rs, n_held1);
                    n_prev     = n_held1;
                    n_held_cnt = 2'd0;
                    n_start    = 1'b0;
                end
            end
            if (!done) begin
                if (c == ssvu_pkg::C_AT) begin
                    n_held0    = c;
                    n_held_cnt = 2'd1;
                end else if (c == ssvu_pkg::C_BS) begin
                    n_esc   = 1'b1;
                    n_prev  = c;
                    n_start = 1'b0;
                end else begin
                    rs      = ssvu_pkg::f_put(rs, (c == ssvu_pkg::C_US) ? ssvu_pkg::C_SP : c);
                    n_prev  = c;
                    n_start = 1'b0;
                end
            end
        end
    end

    assign o_set = rs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held0    <= '0;
            r_held1    <= '0;
            r_held_cnt <= '0;
            r_prev     <= '0;
            r_start    <= 1'b1;
            r_esc      <= 1'b0;
        end else if (i_en) begin
            r_held0    <= n_held0;
            r_held1    <= n_held1;
            r_held_cnt <= n_held_cnt;
            r_prev     <= n_prev;
            r_start    <= n_start;
            r_esc      <= n_esc;
        end
    end

endmodule

// ===== rtl/core/ssvu_result_buf.sv =====
// ssvu_result_buf: result register holding the results of one request,
// handed out one per output handshake; depends on ssvu_pkg

module ssvu_result_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  ssvu_pkg::t_res_set i_set,
    output logic               o_free,
    output logic               o_valid,
    input  logic               i_ready,
    output ssvu_pkg::t_out_item o_item
);

    ssvu_pkg::t_res_set r_set;
    logic               r_valid;
    logic [1:0]         r_idx;
    logic               pop;
    logic               last;

    assign pop    = r_valid && i_ready;
    assign last   = (r_idx == r_set.cnt - 2'd1);
    assign o_free = !r_valid || (pop && last);
    assign o_valid = r_valid;

    always_comb begin
        case (r_idx)
            2'd0:    o_item = r_set.slot[0];
            2'd1:    o_item = r_set.slot[1];
            default: o_item = r_set.slot[2];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            // a request with no result leaves the register empty
            r_valid <= (i_set.cnt != 2'd0);
            r_idx   <= '0;
        end else if (pop) begin
            if (last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_set <= i_set;
        end
    end

endmodule

// ===== rtl/core/ssv_field_unescape.sv =====
// ssv_field_unescape: top level of the field unescape block
// depends on ssvu_pkg, ssvu_decode, ssvu_result_buf
//
// Input channel (i_in_valid / o_in_ready / i_in_item) takes one request per
// cycle: a raw field byte (kind 0) or the end of the field (kind 1).
// Output channel (o_out_valid / i_out_ready / o_out_item) gives the decoded
// bytes; end_of_field marks the last result of a field, and an end request
// always yields exactly one result (has_char 0 if nothing was left).
// A request waits in the input register, is decoded in one pass into up to
// three results, which load the result register when it is free; the first
// result is valid as soon as they are loaded. Throughput is one request per
// cycle while each request gives at most one result and the receiver takes
// each one at once; a request with k results occupies the result register
// until all k are taken, one per output handshake, and the next request is
// decoded in the cycle its last result is taken.
// When the receiver stalls, results hold and the input register fills, then
// o_in_ready drops. Reset empties both registers and returns the field state
// to the start of a field.

module ssv_field_unescape (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ssvu_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ssvu_pkg::t_out_item o_out_item
);

    logic               r_in_valid;
    ssvu_pkg::t_in_item r_in_item;
    logic               load;
    logic               buf_free;
    ssvu_pkg::t_res_set dec_set;

    assign load       = r_in_valid && buf_free;
    assign o_in_ready = !r_in_valid || load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    ssvu_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (load),
        .i_item  (r_in_item),
        .o_set   (dec_set)
    );

    ssvu_result_buf u_result_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_set   (dec_set),
        .o_free  (buf_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule
